// File: rtl/spq_pkg.sv
// spq_pkg: command, result and entry types for the sorted priority queue.
// Used by spq_store and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    spq_op_e            opcode;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } spq_cmd_t;

  typedef struct packed {
    spq_status_e        status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic               queue_empty;
  } spq_res_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } spq_entry_t;

endpackage

`default_nettype wire

// File: rtl/spq_store.sv
// spq_store: entry memory of the queue, one write and one registered read port.
// Depends on spq_pkg for the entry type.
`default_nettype none

module spq_store #(
  parameter int unsigned Depth = 16,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IdxW-1:0]     waddr_i,
  input  wire spq_pkg::spq_entry_t wdata_i,
  input  wire logic [IdxW-1:0]     raddr_i,
  output spq_pkg::spq_entry_t      rdata_o
);
  import spq_pkg::*;

  spq_entry_t mem_q [Depth];
  spq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue held in priority order in a ring memory.
// Depends on spq_pkg and spq_store.
//
// Usage: drive cmd_i and raise start_i; the command transfers at a rising edge where
// start_i is high and busy_o is low. busy_o stays high while the command is worked on.
// Each command gives exactly one result on result_o, marked by result_valid_o for a
// single cycle; the receiver cannot stall, so it must take the result in that cycle.
// Entries sit in a ring buffer (head, tail, count). A dequeue reads the head slot
// at the transfer, and S_DEQ registers that entry into result_o. An enqueue walks
// from the tail toward the head through one compare unit, moving one entry up a slot
// per cycle, until it meets an entry of greater or equal priority. A dropped enqueue
// (full) or a dequeue from empty answers in the cycle after the transfer.
// busy_o falls in the cycle the result is shown, so a new command may follow directly.
// Reset empties the queue (count, head and tail cleared); memory contents are not
// cleared since only slots holding stored entries are ever used.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire spq_pkg::spq_cmd_t cmd_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output spq_pkg::spq_res_t      result_o
);
  import spq_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_PLACE = 4'b0100,
    S_DEQ   = 4'b1000
  } spq_state_e;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] x);
    return (x == LastIdx) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] x);
    return (x == '0) ? LastIdx : x - 1'b1;
  endfunction

  spq_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] left_q, left_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [IdxW-1:0] wr_q, wr_d;
  spq_cmd_t        cmd_q, cmd_d;
  spq_res_t        res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_raddr;
  spq_entry_t      mem_wdata;
  spq_entry_t      mem_rdata;
  spq_entry_t      new_entry;
  logic            stays_ahead;

  assign new_entry.value = cmd_q.item_value;
  assign new_entry.prio  = cmd_q.item_priority;

  // shared compare unit: stored entry keeps its place when its priority is >= the new one
  assign stays_ahead = (mem_rdata.prio >= cmd_q.item_priority);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wr_d        = wr_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = new_entry;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          res_d.out_value    = '0;
          res_d.out_priority = '0;
          res_d.status       = ST_DONE;
          res_d.queue_empty  = (count_q == '0);
          if (cmd_i.opcode == OP_ENQ) begin
            if (count_q == FullCnt) begin
              res_d.status = ST_FULL;
              res_valid_d  = 1'b1;
            end else begin
              wr_d   = tail_q;
              left_d = count_q;
              state_d = (count_q == '0) ? S_PLACE : S_WALK;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
              res_valid_d  = 1'b1;
            end else begin
              state_d = S_DEQ;
            end
          end
        end
      end
      S_WALK: begin
        mem_we = 1'b1;
        if (stays_ahead) begin
          mem_wdata         = new_entry;
          count_d           = count_q + 1'b1;
          tail_d            = idx_inc(tail_q);
          res_d.queue_empty = 1'b0;
          res_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          // move the stored entry one slot toward the tail
          mem_wdata = mem_rdata;
          wr_d      = idx_dec(wr_q);
          left_d    = left_q - 1'b1;
          if (left_q == CntW'(1)) begin
            state_d = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        mem_we            = 1'b1;
        mem_wdata         = new_entry;
        count_d           = count_q + 1'b1;
        tail_d            = idx_inc(tail_q);
        res_d.queue_empty = 1'b0;
        res_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      S_DEQ: begin
        res_d.out_value    = mem_rdata.value;
        res_d.out_priority = mem_rdata.prio;
        res_d.queue_empty  = (count_q == CntW'(1));
        head_d             = idx_inc(head_q);
        count_d            = count_q - 1'b1;
        res_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a dequeue reads the head; otherwise fetch the entry just below the next write slot
  assign mem_raddr = (state_q == S_IDLE) && (cmd_i.opcode == OP_DEQ) ? head_q : idx_dec(wr_d);

  spq_store #(
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      wr_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      wr_q        <= wr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// File: bench/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// sorted_priority_queue_test: self-checking bench for the sorted priority queue.
// Depends on spq_pkg and sorted_priority_queue; predicts every result in-bench.

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS  = 630;
  localparam int unsigned SETTLE_CYCLES = QUEUE_DEPTH + 4;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] rank;
  } held_entry_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  spq_cmd_t cmd_i   = '0;
  logic     busy_o;
  logic     result_valid_o;
  spq_res_t result_o;

  // entries in leaving order, head first
  held_entry_t held_entries[$];
  spq_res_t    expected_results[$];

  int unsigned fail_count    = 0;
  int unsigned enq_count     = 0;
  int unsigned deq_count     = 0;
  int unsigned full_drops    = 0;
  int unsigned empty_deqs    = 0;
  int unsigned checked_count = 0;
  int unsigned deepest_fill  = 0;

  always #10 clk_i = ~clk_i;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  function automatic spq_res_t priority_queue_apply(input spq_cmd_t cmd);
    spq_res_t    res;
    int unsigned pos;
    held_entry_t head;
    res = '0;
    res.status = ST_DONE;
    if (cmd.opcode == OP_ENQ) begin
      enq_count++;
      if (held_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        full_drops++;
      end else begin
        // goes behind every entry of greater or equal rank
        pos = 0;
        while (pos < held_entries.size() &&
               $signed(held_entries[pos].rank) >= $signed(cmd.item_priority)) begin
          pos++;
        end
        held_entries.insert(pos, '{data: cmd.item_value, rank: cmd.item_priority});
        if (held_entries.size() > deepest_fill) begin
          deepest_fill = held_entries.size();
        end
      end
    end else begin
      deq_count++;
      if (held_entries.size() == 0) begin
        res.status = ST_EMPTY;
        empty_deqs++;
      end else begin
        head = held_entries.pop_front();
        res.out_value    = head.data;
        res.out_priority = head.rank;
      end
    end
    res.queue_empty = (held_entries.size() == 0);
    return res;
  endfunction

  function automatic spq_cmd_t random_command(input int unsigned enq_pct);
    spq_cmd_t cmd;
    cmd.opcode     = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
    cmd.item_value = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // narrow range so that ties are common
        cmd.item_priority = $signed($urandom_range(6)) - 3;
      end
      4: begin
        cmd.item_priority = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      default: begin
        cmd.item_priority = $urandom();
      end
    endcase
    return cmd;
  endfunction

  // one command transfer; start_i stays high for the caller to reuse or lower
  task automatic send_command(input spq_cmd_t cmd);
    start_i <= 1'b1;
    cmd_i   <= cmd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_results.push_back(priority_queue_apply(cmd));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    spq_res_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, result_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        check_field("status", 32'(want.status), 32'(result_o.status));
        check_field("out_value", want.out_value, result_o.out_value);
        check_field("out_priority", want.out_priority, result_o.out_priority);
        check_field("queue_empty", 32'(want.queue_empty), 32'(result_o.queue_empty));
      end
    end
  end

  task automatic test_empty_dequeue();
    spq_cmd_t cmd;
    cmd = '{opcode: OP_DEQ, item_value: 32'sh7FFF_FFFF, item_priority: 32'sh8000_0000};
    send_command(cmd);
  endtask

  // fills the store with extreme ranks, each one twice so ties leave in order
  task automatic test_sorted_fill();
    spq_cmd_t cmd;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      cmd.opcode = OP_ENQ;
      case (i % 8)
        0: cmd.item_priority = 32'sh7FFF_FFFF;
        1: cmd.item_priority = 32'sh8000_0000;
        2: cmd.item_priority = 32'sd0;
        3: cmd.item_priority = -32'sd1;
        4: cmd.item_priority = 32'sd1;
        5: cmd.item_priority = 32'sh4000_0000;
        6: cmd.item_priority = -32'sd5;
        default: cmd.item_priority = 32'sh8000_0001;
      endcase
      if (i == 0) begin
        cmd.item_value = 32'sh7FFF_FFFF;
      end else if (i == 1) begin
        cmd.item_value = 32'sh8000_0000;
      end else begin
        cmd.item_value = $urandom();
      end
      send_command(cmd);
    end
  endtask

  task automatic test_full_drop();
    spq_cmd_t cmd;
    cmd = '{opcode: OP_ENQ, item_value: 32'sh1234_5678, item_priority: 32'sh7FFF_FFFF};
    send_command(cmd);
    cmd.opcode = OP_DEQ;
    send_command(cmd);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned enq_pct;
    int unsigned next_drain;
    sent       = 0;
    next_drain = 100 + $urandom_range(50);
    while (sent < item_total) begin
      case ($urandom_range(2))
        0: enq_pct = 80;
        1: enq_pct = 50;
        default: enq_pct = 25;
      endcase
      burst_len = $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst_len && sent < item_total; i++) begin
        send_command(random_command(enq_pct));
        sent++;
      end
      if (sent >= next_drain) begin
        wait_for_results();
        next_drain = sent + 100 + $urandom_range(50);
      end else if ($urandom_range(3) != 0) begin
        // gaps up to a full enqueue walk so every phase gets hit
        pause_sender($urandom_range(1, 20));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_dequeue();
    test_sorted_fill();
    test_full_drop();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d enqueues (%0d dropped when full) and %0d dequeues (%0d on empty)",
             enq_count, full_drops, deq_count, empty_deqs);
    $display("checked %0d results, deepest fill %0d of %0d entries",
             checked_count, deepest_fill, QUEUE_DEPTH);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
